FILE: rtl/frt_pkg.sv
// fragment reassembly tracker: shared widths, table sizing, codes and entry type
// no dependencies; used by the channel interfaces and the top-level module

package frt_pkg;

	// item field widths
	localparam int STREAM_W = 16;
	localparam int BLOCK_W  = 32;
	localparam int FIDX_W   = 16;
	localparam int LEN_W    = 17;
	localparam int OCNT_W   = 7;
	localparam int OLL_W    = 11;
	localparam int CLEN_W   = 17;
	localparam int KEY_W    = STREAM_W + BLOCK_W;

	// table sizing
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int MAX_FRAGMENTS = 64;
	localparam int CNT_W         = $clog2(MAX_FRAGMENTS + 1);
	localparam int MAPI_W        = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int MTU_BYTES     = 1024;
	localparam int LL_W          = $clog2(MTU_BYTES + 1);

	// reciprocal for the block length split, exact after one correction step
	localparam int DIV_SH  = LEN_W;
	localparam int RECIP   = (1 << DIV_SH) / MTU_BYTES;
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W  = LEN_W + RECIP_W;
	localparam int REM_W   = LL_W + 1;

	typedef enum logic [1:0] {
		REQ_ADD_FRAG  = 2'd0,
		REQ_ADD_BLOCK = 2'd1,
		REQ_DELETE    = 2'd2,
		REQ_QUERY     = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_BOUNDS   = 3'd3,
		ST_BADLEN   = 3'd4,
		ST_EXISTS   = 3'd5,
		ST_NOTFOUND = 3'd6,
		ST_FULL     = 3'd7
	} status_t;

	typedef logic [MAX_FRAGMENTS-1:0] map_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		map_t             map;
		logic [LL_W-1:0]  ll;
	} entry_t;

	typedef struct packed {
		req_type_t           req_type;
		logic [STREAM_W-1:0] stream_id;
		logic [BLOCK_W-1:0]  block_id;
		logic [FIDX_W-1:0]   fragment_index;
		logic [FIDX_W-1:0]   fragment_total;
		logic [LEN_W-1:0]    byte_length;
	} req_t;

endpackage

FILE: rtl/frt_if.sv
// fragment reassembly tracker: request and result channel interfaces
// depends on frt_pkg

interface frt_req_if;
	logic                           valid;
	logic                           ready;
	frt_pkg::req_type_t             req_type;
	logic [frt_pkg::STREAM_W-1:0]   stream_id;
	logic [frt_pkg::BLOCK_W-1:0]    block_id;
	logic [frt_pkg::FIDX_W-1:0]     fragment_index;
	logic [frt_pkg::FIDX_W-1:0]     fragment_total;
	logic [frt_pkg::LEN_W-1:0]      byte_length;

	modport source (output valid, req_type, stream_id, block_id, fragment_index,
		fragment_total, byte_length, input ready);
	modport sink (input valid, req_type, stream_id, block_id, fragment_index,
		fragment_total, byte_length, output ready);
endinterface

interface frt_rsp_if;
	logic                         valid;
	logic                         ready;
	frt_pkg::status_t             status;
	logic                         complete;
	logic [frt_pkg::OCNT_W-1:0]   fragment_count;
	logic [frt_pkg::OLL_W-1:0]    last_length;
	logic [frt_pkg::CLEN_W-1:0]   content_length;

	modport source (output valid, status, complete, fragment_count, last_length,
		content_length, input ready);
	modport sink (input valid, status, complete, fragment_count, last_length,
		content_length, output ready);
endinterface

FILE: rtl/frt_ram.sv
// fragment reassembly tracker: generic single-port-write, registered-read ram
// no dependencies

module frt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/fragment_reassembly_tracker_top.sv
// fragment reassembly tracker top level: key scan, entry update and result register
// depends on frt_pkg, frt_if (frt_req_if, frt_rsp_if) and frt_ram

// The tracker keeps a table of TABLE_ENTRIES blocks keyed by stream and block
// number, each with a fragment presence map, a fragment count and the length of
// the final fragment. One request item is taken at a time and gives exactly one
// result item. From acceptance, the key memory is read one entry per cycle to
// find the lowest matching valid entry and the lowest free one, and a drain step
// compares the last key; then the entry data memory is read, and the entry is
// modified and written back. The request side opens again on the cycle after,
// so no new item is taken before the last one is through. The result sits in
// an output register, so the next request is taken while an earlier result
// still waits for the sink; that request then holds in its update step until
// the sink takes the earlier result. Valid bits live in flip-flops and are
// cleared by reset, so there is no clearing pass; keys and entry data are only
// ever read behind a set valid bit. An absent block reads as complete.

module fragment_reassembly_tracker_top (
	input  logic         clk,
	input  logic         arst_n,
	frt_req_if.sink      req,
	frt_rsp_if.source    rsp
);

	localparam int TE     = frt_pkg::TABLE_ENTRIES;
	localparam int IDX_W  = frt_pkg::IDX_W;
	localparam int CNT_W  = frt_pkg::CNT_W;
	localparam int LL_W   = frt_pkg::LL_W;
	localparam int LEN_W  = frt_pkg::LEN_W;
	localparam int FIDX_W = frt_pkg::FIDX_W;
	localparam int MTU    = frt_pkg::MTU_BYTES;
	localparam int MAXF   = frt_pkg::MAX_FRAGMENTS;
	// content length before saturation
	localparam int CL_W   = CNT_W + LL_W + 1;
	localparam int ENT_W  = $bits(frt_pkg::entry_t);

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		DRAIN,
		RD,
		EXEC
	} state_t;

	state_t state_q;

	// request held for the whole operation
	frt_pkg::req_t req_q;

	// scan bookkeeping
	logic [IDX_W-1:0] scan_addr_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_addr_s1;
	logic             hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [TE-1:0] valid_q;

	// length split pipeline
	logic [frt_pkg::PROD_W-1:0] prod_s1;
	logic [LEN_W-1:0]           q_est;
	logic [LEN_W-1:0]           q_s2;
	logic [frt_pkg::REM_W-1:0]  rem_s2;

	// memory ports
	logic [frt_pkg::KEY_W-1:0] key_rd;
	logic [frt_pkg::KEY_W-1:0] req_key;
	frt_pkg::entry_t           ent_rd;
	logic [ENT_W-1:0]          ent_rd_raw;
	frt_pkg::entry_t           wr_ent;
	logic                      key_we;
	logic                      data_we;
	logic [IDX_W-1:0]          wr_idx;

	// result registers
	logic                        rsp_valid_q;
	frt_pkg::status_t            status_q;
	logic                        complete_q;
	logic [frt_pkg::OCNT_W-1:0]  fcount_q;
	logic [frt_pkg::OLL_W-1:0]   lastlen_q;
	logic [frt_pkg::CLEN_W-1:0]  clen_q;

	// execute-stage decisions
	logic             accept;
	logic             load;
	frt_pkg::status_t ex_status;
	frt_pkg::entry_t  rep_ent;
	logic             rep_none;
	logic             set_valid;
	logic             clr_valid;

	// report figures
	logic                       rep_complete;
	logic [CL_W-1:0]            rep_clen_full;
	logic [frt_pkg::CLEN_W-1:0] rep_clen;

	// fragment checks
	logic                       frag_final;
	logic                       frag_badlen;
	logic                       new_in_range;
	logic [frt_pkg::MAPI_W-1:0] bit_idx;

	// whole block split
	logic                     rem_over;
	logic [LEN_W-1:0]         q_fix;
	logic [frt_pkg::REM_W-1:0] r_fix;
	logic [LEN_W:0]           blk_cnt;
	logic [LL_W-1:0]          blk_ll;

	function automatic frt_pkg::map_t map_of(input logic [CNT_W-1:0] c);
		frt_pkg::map_t m;
		if (32'(c) >= MAXF) begin
			m = '1;
		end else begin
			m = (frt_pkg::map_t'(1) << c) - frt_pkg::map_t'(1);
		end
		return m;
	endfunction

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == IDLE);
	assign load      = (state_q == EXEC) && (!rsp_valid_q || rsp.ready);
	assign req_key   = {req_q.stream_id, req_q.block_id};

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.req_type       <= req.req_type;
			req_q.stream_id      <= req.stream_id;
			req_q.block_id       <= req.block_id;
			req_q.fragment_index <= req.fragment_index;
			req_q.fragment_total <= req.fragment_total;
			req_q.byte_length    <= req.byte_length;
		end
	end

	// key scan: one key read per cycle, compared in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q  <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_addr_s1  <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			cmp_vld_s1  <= (state_q == SCAN);
			cmp_addr_s1 <= scan_addr_q;
			if (accept) begin
				scan_addr_q  <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (state_q == SCAN) begin
					scan_addr_q <= scan_addr_q + IDX_W'(1);
				end
				if (cmp_vld_s1) begin
					// lowest matching valid entry wins
					if (!hit_found_q && valid_q[cmp_addr_s1] && key_rd == req_key) begin
						hit_found_q <= 1'b1;
						hit_idx_q   <= cmp_addr_s1;
					end
					// lowest free entry for allocation
					if (!free_found_q && !valid_q[cmp_addr_s1]) begin
						free_found_q <= 1'b1;
						free_idx_q   <= cmp_addr_s1;
					end
				end
			end
		end
	end

	// length / mtu: reciprocal estimate, then remainder; settles during the scan
	assign q_est = LEN_W'(prod_s1 >> frt_pkg::DIV_SH);

	always_ff @(posedge clk) begin
		prod_s1 <= frt_pkg::PROD_W'(req_q.byte_length)
			* frt_pkg::PROD_W'(frt_pkg::RECIP);
		q_s2    <= q_est;
		rem_s2  <= frt_pkg::REM_W'(req_q.byte_length
			- LEN_W'((LEN_W + LL_W)'(q_est) * (LEN_W + LL_W)'(MTU)));
	end

	// estimate is low by at most one
	assign rem_over = (32'(rem_s2) >= MTU);
	assign q_fix    = rem_over ? q_s2 + LEN_W'(1) : q_s2;
	assign r_fix    = rem_over ? rem_s2 - frt_pkg::REM_W'(MTU) : rem_s2;
	assign blk_cnt  = (LEN_W + 1)'(q_fix) + (LEN_W + 1)'(r_fix != '0);

	always_comb begin
		if (r_fix != '0) begin
			blk_ll = LL_W'(r_fix);
		end else if (req_q.byte_length != '0) begin
			blk_ll = LL_W'(MTU);
		end else begin
			blk_ll = '0;
		end
	end

	// key and entry data memories
	frt_ram #(
		.WIDTH (frt_pkg::KEY_W),
		.DEPTH (TE)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_idx),
		.wdata (req_key),
		.raddr (scan_addr_q),
		.rdata (key_rd)
	);

	frt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TE)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (wr_idx),
		.wdata (wr_ent),
		.raddr (hit_idx_q),
		.rdata (ent_rd_raw)
	);

	assign ent_rd = frt_pkg::entry_t'(ent_rd_raw);

	// fragment checks
	assign frag_final   = ((LEN_W)'(req_q.fragment_index) + LEN_W'(1))
		== LEN_W'(req_q.fragment_total);
	assign frag_badlen  = frag_final ? (32'(req_q.byte_length) > MTU)
		: (32'(req_q.byte_length) != MTU);
	assign new_in_range = (req_q.fragment_total != '0)
		&& (32'(req_q.fragment_total) <= MAXF)
		&& (req_q.fragment_index < req_q.fragment_total);
	assign bit_idx      = req_q.fragment_index[frt_pkg::MAPI_W-1:0];

	// request decode and entry update
	always_comb begin
		ex_status = frt_pkg::ST_OK;
		rep_ent   = ent_rd;
		rep_none  = 1'b0;
		wr_ent    = ent_rd;
		wr_idx    = hit_idx_q;
		key_we    = 1'b0;
		data_we   = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		unique case (req_q.req_type)
			frt_pkg::REQ_ADD_FRAG: begin
				if (!hit_found_q) begin
					rep_none = 1'b1;
					priority if (!new_in_range) begin
						ex_status = frt_pkg::ST_BOUNDS;
					end else if (!free_found_q) begin
						ex_status = frt_pkg::ST_FULL;
					end else if (frag_badlen) begin
						ex_status = frt_pkg::ST_BADLEN;
					end else begin
						// new entry with just this fragment
						rep_none   = 1'b0;
						wr_idx     = free_idx_q;
						wr_ent.cnt = CNT_W'(req_q.fragment_total);
						wr_ent.map = frt_pkg::map_t'(1) << bit_idx;
						wr_ent.ll  = frag_final ? LL_W'(req_q.byte_length) : '0;
						rep_ent    = wr_ent;
						key_we     = load;
						data_we    = load;
						set_valid  = load;
					end
				end else begin
					priority if (req_q.fragment_index >= FIDX_W'(ent_rd.cnt)) begin
						ex_status = frt_pkg::ST_BOUNDS;
					end else if (ent_rd.map[bit_idx]) begin
						ex_status = frt_pkg::ST_DUP;
					end else if (req_q.fragment_total != FIDX_W'(ent_rd.cnt)) begin
						ex_status = frt_pkg::ST_MISMATCH;
					end else if (frag_badlen) begin
						ex_status = frt_pkg::ST_BADLEN;
					end else begin
						wr_ent.map = ent_rd.map | (frt_pkg::map_t'(1) << bit_idx);
						if (frag_final) begin
							wr_ent.ll = LL_W'(req_q.byte_length);
						end
						rep_ent = wr_ent;
						data_we = load;
					end
				end
			end
			frt_pkg::REQ_ADD_BLOCK: begin
				if (hit_found_q) begin
					ex_status = frt_pkg::ST_EXISTS;
				end else begin
					rep_none = 1'b1;
					priority if (32'(blk_cnt) > MAXF) begin
						ex_status = frt_pkg::ST_BOUNDS;
					end else if (!free_found_q) begin
						ex_status = frt_pkg::ST_FULL;
					end else begin
						// whole block present at once
						rep_none   = 1'b0;
						wr_idx     = free_idx_q;
						wr_ent.cnt = CNT_W'(blk_cnt);
						wr_ent.map = map_of(CNT_W'(blk_cnt));
						wr_ent.ll  = blk_ll;
						rep_ent    = wr_ent;
						key_we     = load;
						data_we    = load;
						set_valid  = load;
					end
				end
			end
			frt_pkg::REQ_DELETE, frt_pkg::REQ_QUERY: begin
				if (!hit_found_q) begin
					ex_status = frt_pkg::ST_NOTFOUND;
					rep_none  = 1'b1;
				end else if (req_q.req_type == frt_pkg::REQ_DELETE) begin
					// reported as it was before removal
					clr_valid = load;
				end
			end
			default: begin
				ex_status = frt_pkg::ST_OK;
			end
		endcase
	end

	// completeness and byte length of the reported entry
	always_comb begin
		logic                       last_seen;
		logic [CNT_W-1:0]           c_m1;
		logic [CNT_W-1:0]           base_cnt;
		logic [LL_W-1:0]            tail;
		frt_pkg::map_t              mask;
		mask          = map_of(rep_ent.cnt);
		c_m1          = rep_ent.cnt - CNT_W'(1);
		last_seen     = (rep_ent.cnt != '0) && rep_ent.map[c_m1[frt_pkg::MAPI_W-1:0]];
		base_cnt      = last_seen ? c_m1 : rep_ent.cnt;
		tail          = last_seen ? rep_ent.ll : '0;
		rep_complete  = ((rep_ent.map & mask) == mask);
		rep_clen_full = CL_W'(base_cnt) * CL_W'(MTU) + CL_W'(tail);
		if (rep_clen_full > CL_W'({frt_pkg::CLEN_W{1'b1}})) begin
			rep_clen = '1;
		end else begin
			rep_clen = frt_pkg::CLEN_W'(rep_clen_full);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rsp_valid_q <= 1'b0;
			status_q    <= frt_pkg::ST_OK;
			complete_q  <= 1'b0;
			fcount_q    <= '0;
			lastlen_q   <= '0;
			clen_q      <= '0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
				status_q    <= ex_status;
				complete_q  <= rep_none ? 1'b1 : rep_complete;
				fcount_q    <= rep_none ? '0 : frt_pkg::OCNT_W'(rep_ent.cnt);
				lastlen_q   <= rep_none ? '0 : frt_pkg::OLL_W'(rep_ent.ll);
				clen_q      <= rep_none ? '0 : rep_clen;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (req.valid) begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (scan_addr_q == IDX_W'(TE - 1)) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					state_q <= RD;
				end
				RD: begin
					state_q <= EXEC;
				end
				EXEC: begin
					if (load) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.complete       = complete_q;
	assign rsp.fragment_count = fcount_q;
	assign rsp.last_length    = lastlen_q;
	assign rsp.content_length = clen_q;

	// a new entry never lands on a live one
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (free_found_q && !valid_q[free_idx_q]))
		else $error("allocation over a valid entry");

	// data written without a new key only for the entry that was found
	a_update_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(data_we && !key_we) |-> (hit_found_q && valid_q[hit_idx_q]))
		else $error("entry update without a matching entry");

	// a result appears only at the end of an operation
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == EXEC))
		else $error("result raised outside the execute step");

	// a delete leaves the entry invalid
	a_delete: assert property (@(posedge clk) disable iff (!arst_n)
		clr_valid |=> !valid_q[$past(hit_idx_q)])
		else $error("deleted entry still valid");

endmodule
